FILE: rtl/sfbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbl_pkg
// Shared types and codes of the size-ordered free block list.
// ----------------------------------------------------------------------------
package sfbl_pkg;

    // Payload field widths of the item channels
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 2;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 2'd0,
        KIND_POP_SIZE  = 2'd1,
        KIND_POP_INDEX = 2'd2,
        KIND_POP_END   = 2'd3
    } kind_t;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FOUND    = 2'd1,
        STAT_NOMATCH  = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/sfbl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbl_req_if
// Request channel: valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface sfbl_req_if;
    logic                                valid;
    logic                                ready;
    sfbl_pkg::kind_t                     kind;
    logic [sfbl_pkg::FIELD_W-1:0]        block_index;
    logic [sfbl_pkg::FIELD_W-1:0]        block_len;

    modport source (output valid, output kind, output block_index, output block_len,
                    input ready);
    modport sink   (input valid, input kind, input block_index, input block_len,
                    output ready);
endinterface

FILE: rtl/sfbl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbl_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface sfbl_rsp_if;
    logic                                valid;
    logic                                ready;
    sfbl_pkg::status_t                   status;
    logic [sfbl_pkg::FIELD_W-1:0]        found_index;
    logic [sfbl_pkg::FIELD_W-1:0]        found_size;

    modport source (output valid, output status, output found_index, output found_size,
                    input ready);
    modport sink   (input valid, input status, input found_index, input found_size,
                    output ready);
endinterface

FILE: rtl/sorted_free_block_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_free_block_list_core
// Free block list kept in ascending size order in a single RAM.
// ----------------------------------------------------------------------------
// Holds up to MAX_BLOCKS free blocks (start, size) in one RAM, sorted by size
// with equal sizes in arrival order. Each request item (insert, pop by size
// = best fit, pop by start, pop by end address) yields exactly one response
// item. The list is walked through the RAM's single read port, one entry per
// cycle, and entries are shifted up or down in the same pass through the
// write port. The response is registered; an insert into a full list and any
// request on an empty list skip the walk. The finish step waits while the
// previous response is still held. One request is worked on at a time; a new
// request is accepted while the previous response still waits in the output
// register. Indexes and sizes use the low min(ADDR_BITS,16) bits.
// ----------------------------------------------------------------------------
module sorted_free_block_list_core #(
    parameter int unsigned MAX_BLOCKS = 16,
    parameter int unsigned ADDR_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sfbl_req_if.sink   req,
    sfbl_rsp_if.source rsp
);
    import sfbl_pkg::*;

    localparam int unsigned VAL_W = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned ENT_W = 2 * VAL_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Control and payload registers
    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    kind_t             kind_reg,    kind_next;
    logic [VAL_W-1:0]  idx_reg,     idx_next;
    logic [VAL_W-1:0]  sz_reg,      sz_next;
    logic [IDX_W-1:0]  rd_addr_reg, rd_addr_next;
    logic              issue_reg,   issue_next;
    logic              dv_reg,      dv_next;
    logic [IDX_W-1:0]  dpos_reg,    dpos_next;
    logic              found_reg,   found_next;
    status_t           status_reg,  status_next;
    logic [VAL_W-1:0]  fidx_reg,    fidx_next;
    logic [VAL_W-1:0]  fsz_reg,     fsz_next;
    logic              ovalid_reg,  ovalid_next;
    status_t           ostat_reg,   ostat_next;
    logic [VAL_W-1:0]  ofidx_reg,   ofidx_next;
    logic [VAL_W-1:0]  ofsz_reg,    ofsz_next;

    // RAM port signals
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;

    logic [VAL_W-1:0]  ent_start;
    logic [VAL_W-1:0]  ent_len;
    logic [VAL_W:0]    ent_end;
    logic              ent_match;
    logic [IDX_W-1:0]  last_pos;
    logic [VAL_W-1:0]  req_idx;
    logic [VAL_W-1:0]  req_sz;

    sfbl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Entry decode and match of the entry just read
    assign ent_start = ram_rdata[ENT_W-1:VAL_W];
    assign ent_len   = ram_rdata[VAL_W-1:0];
    assign ent_end   = {1'b0, ent_start} + {1'b0, ent_len};
    assign last_pos  = IDX_W'(count_reg - CNT_ONE);
    assign req_idx   = req.block_index[VAL_W-1:0];
    assign req_sz    = req.block_len[VAL_W-1:0];

    always_comb
    begin
        case (kind_reg)
            KIND_POP_SIZE:  ent_match = (sz_reg <= ent_len);
            KIND_POP_INDEX: ent_match = (idx_reg == ent_start);
            default:        ent_match = (ent_end == {1'b0, idx_reg});
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        sz_next      = sz_reg;
        rd_addr_next = rd_addr_reg;
        issue_next   = issue_reg;
        dv_next      = 1'b0;
        dpos_next    = dpos_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        fidx_next    = fidx_reg;
        fsz_next     = fsz_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        ostat_next   = ostat_reg;
        ofidx_next   = ofidx_reg;
        ofsz_next    = ofsz_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = {idx_reg, sz_reg};
        req.ready    = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    idx_next   = req_idx;
                    sz_next    = req_sz;
                    found_next = 1'b0;
                    fidx_next  = '0;
                    fsz_next   = '0;
                    if (req.kind == KIND_INSERT)
                    begin
                        if (count_reg == CNT_MAX)
                        begin
                            status_next = STAT_FULL;
                            state_next  = S_FINISH;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = {req_idx, req_sz};
                            count_next  = CNT_ONE;
                            status_next = STAT_INSERTED;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            // walk from the largest entry downward
                            rd_addr_next = last_pos;
                            issue_next   = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STAT_NOMATCH;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        // walk from the smallest entry upward
                        rd_addr_next = '0;
                        issue_next   = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read issue, one address per cycle
                if (issue_reg)
                begin
                    dv_next   = 1'b1;
                    dpos_next = rd_addr_reg;
                    if (kind_reg == KIND_INSERT)
                    begin
                        issue_next   = (rd_addr_reg != '0);
                        rd_addr_next = rd_addr_reg - IDX_W'(1);
                    end
                    else
                    begin
                        issue_next   = (rd_addr_reg != last_pos);
                        rd_addr_next = rd_addr_reg + IDX_W'(1);
                    end
                end

                // process the entry read in the previous cycle
                if (dv_reg)
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = dpos_reg + IDX_W'(1);
                        if (ent_len > sz_reg)
                        begin
                            // larger entry moves up one slot
                            ram_wdata = ram_rdata;
                            if (dpos_reg == '0)
                            begin
                                state_next = S_PLACE;
                            end
                        end
                        else
                        begin
                            count_next  = count_reg + CNT_ONE;
                            status_next = STAT_INSERTED;
                            state_next  = S_FINISH;
                            issue_next  = 1'b0;
                            dv_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            // entries after the removed one move down
                            ram_we    = 1'b1;
                            ram_waddr = dpos_reg - IDX_W'(1);
                            ram_wdata = ram_rdata;
                        end
                        else if (ent_match)
                        begin
                            found_next = 1'b1;
                            fidx_next  = ent_start;
                            fsz_next   = ent_len;
                        end

                        if (dpos_reg == last_pos)
                        begin
                            state_next = S_FINISH;
                            issue_next = 1'b0;
                            dv_next    = 1'b0;
                            if (found_next)
                            begin
                                count_next  = count_reg - CNT_ONE;
                                status_next = STAT_FOUND;
                            end
                            else
                            begin
                                status_next = STAT_NOMATCH;
                            end
                        end
                    end
                end
            end

            S_PLACE:
            begin
                // new block becomes the smallest entry
                ram_we      = 1'b1;
                count_next  = count_reg + CNT_ONE;
                status_next = STAT_INSERTED;
                state_next  = S_FINISH;
            end

            S_FINISH:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = status_reg;
                    ofidx_next  = fidx_reg;
                    ofsz_next   = fsz_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            issue_reg  <= 1'b0;
            dv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            dv_reg     <= dv_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        idx_reg     <= idx_next;
        sz_reg      <= sz_next;
        rd_addr_reg <= rd_addr_next;
        dpos_reg    <= dpos_next;
        status_reg  <= status_next;
        fidx_reg    <= fidx_next;
        fsz_reg     <= fsz_next;
        ostat_reg   <= ostat_next;
        ofidx_reg   <= ofidx_next;
        ofsz_reg    <= ofsz_next;
    end

    assign rsp.valid       = ovalid_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.found_index = FIELD_W'(ofidx_reg);
    assign rsp.found_size  = FIELD_W'(ofsz_reg);

`ifndef NO_ASSERTIONS
    // list never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_MAX)
        else $error("entry count above capacity");

    // count moves by at most one entry per request
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CNT_ONE) ||
         (count_reg == $past(count_reg) - CNT_ONE)))
        else $error("entry count jumped");

    // RAM writes only while a request is in progress or being accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_IDLE)) |-> (req.valid && (req.kind == KIND_INSERT)))
        else $error("RAM write while idle");

    // read data is only tracked inside a scan
    assert property (@(posedge clk) disable iff (!rst_n) dv_reg |-> (state_reg == S_SCAN))
        else $error("read data valid outside scan");

    // a new response is loaded only from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("response loaded outside finish");
`endif

endmodule

FILE: rtl/sfbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfbl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
